[hw/rtl/nearest_timestamp_pair_matcher_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp pair matcher
// Clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TIMESTAMP_PAIR_MATCHER_ASSERT_SVH
`define NEAREST_TIMESTAMP_PAIR_MATCHER_ASSERT_SVH
// same-cycle implication
`define NTPM_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define NTPM_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/ntpm_pkg.sv]
// ----------------------------------------------------------------------------
// ntpm_pkg
// Types, codes and constants shared by the pair matcher modules.
// ----------------------------------------------------------------------------
package ntpm_pkg;
    localparam int TimeW = 48;
    localparam int TagW  = 16;
    localparam int DiffW = 24;
    localparam int DropW = 5;
    localparam int FrameW = 32;
    localparam int DefDepth = 16;
    localparam logic [DiffW-1:0] DiffReset = 24'd20000;

    localparam logic [1:0] OpPushP = 2'd0;
    localparam logic [1:0] OpPushS = 2'd1;
    localparam logic [1:0] OpMatch = 2'd2;
    localparam logic [1:0] OpClear = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [TimeW-1:0] timestamp;
        logic [TagW-1:0]  tag;
        logic             usable;
    } t_in;

    typedef struct packed {
        logic              matched;
        logic [FrameW-1:0] frame_number;
        logic [TimeW-1:0]  frame_time;
        logic [TagW-1:0]  primary_tag;
        logic [TagW-1:0]  secondary_tag;
        logic [DropW-1:0] primary_dropped;
        logic [DropW-1:0] secondary_dropped;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic clear;     // empty both buffers
        logic ins_step;  // one insertion-shift step
        logic ins_done;  // finish insertion
        logic scan_init; // start nearest search
        logic scan_step; // compare one secondary entry
        logic decide;    // evaluate gap and stale tests
        logic rm_step;   // one removal-shift step
        logic emit;      // drive result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic is_match;
        logic is_clear;
        logic ins_last;
        logic scan_last;
        logic empty;
        logic hit;
        logic p_stale;
        logic s_stale;
        logic rm_last;
    } t_sts;
endpackage

[hw/rtl/ntpm_datapath.sv]
// ----------------------------------------------------------------------------
// ntpm_datapath
// Two sorted buffers with a one-entry-per-cycle shift unit and scan unit.
// ----------------------------------------------------------------------------
module ntpm_datapath import ntpm_pkg::*; #(
    parameter int BUFFER_DEPTH = DefDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in              i_item,
    input  logic [DiffW-1:0] i_max_diff,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output t_out             o_res
);
    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [TimeW-1:0] r_pt [2][BUFFER_DEPTH];
    logic [TagW-1:0]  r_pg [2][BUFFER_DEPTH];
    logic [CW-1:0]    r_cnt [2];
    logic [FrameW-1:0] r_frame;
    t_in              r_item;
    logic             r_sel;   // buffer being shifted
    logic [CW-1:0]    r_idx;
    logic [IW-1:0]    r_best;
    logic [TimeW-1:0] r_bgap;
    logic [DropW-1:0] r_pd, r_sd;
    logic             r_full;
    logic             r_rm_best;
    logic [CW-1:0]    r_rm_end;

    logic [TimeW-1:0] cur_t, gap, p0;
    logic [TimeW:0]   psum, ssum;

    assign p0 = r_pt[0][0];
    assign cur_t = r_pt[1][r_idx[IW-1:0]];
    assign gap = (cur_t >= p0) ? cur_t - p0 : p0 - cur_t;
    assign psum = {1'b0, p0} + {{(TimeW+1-DiffW){1'b0}}, i_max_diff};
    assign ssum = {1'b0, r_pt[1][r_cnt[1][IW-1:0] - IW'(1)]}
                + {{(TimeW+1-DiffW){1'b0}}, i_max_diff};

    // insertion walks from the tail down: at index r_idx, compare entry r_idx-1
    logic [TimeW-1:0] prev_t;
    assign prev_t = r_pt[r_sel][r_idx[IW-1:0] - IW'(1)];

    always_comb begin
        o_sts.is_push  = (r_item.operation == OpPushP || r_item.operation == OpPushS)
                         && r_item.usable;
        o_sts.is_match = (r_item.operation == OpMatch);
        o_sts.is_clear = (r_item.operation == OpClear);
        o_sts.ins_last = (r_idx == '0) || (prev_t <= r_item.timestamp);
        o_sts.scan_last = (r_idx >= r_cnt[1]);
        o_sts.empty    = (r_cnt[0] == '0) || (r_cnt[1] == '0);
        o_sts.hit      = (r_bgap <= {{(TimeW-DiffW){1'b0}}, i_max_diff});
        o_sts.p_stale  = {1'b0, r_pt[1][0]} > psum;
        o_sts.s_stale  = ssum < {1'b0, p0};
        o_sts.rm_last  = (r_idx + CW'(1) >= r_rm_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_frame  <= '0;
            o_res    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_item <= i_item;
                r_sel  <= (i_item.operation == OpPushS);
                r_pd   <= '0;
                r_sd   <= '0;
                if (i_item.operation == OpPushS)
                    r_full <= (r_cnt[1] == CW'(BUFFER_DEPTH));
                else
                    r_full <= (r_cnt[0] == CW'(BUFFER_DEPTH));
                r_idx <= (i_item.operation == OpPushS) ? r_cnt[1] : r_cnt[0];
            end
            if (i_cmd.clear) begin
                r_cnt[0] <= '0;
                r_cnt[1] <= '0;
                r_frame  <= '0;
            end
            if (i_cmd.ins_step) begin
                // not full: shift entry idx-1 up to idx. full: walk tracks position only
                if (r_idx != CW'(BUFFER_DEPTH) && !r_full) begin
                    r_pt[r_sel][r_idx[IW-1:0]] <= prev_t;
                    r_pg[r_sel][r_idx[IW-1:0]] <= r_pg[r_sel][r_idx[IW-1:0] - IW'(1)];
                end
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd.ins_done) begin
                if (!r_full) begin
                    r_pt[r_sel][r_idx[IW-1:0]] <= r_item.timestamp;
                    r_pg[r_sel][r_idx[IW-1:0]] <= r_item.tag;
                    r_cnt[r_sel] <= r_cnt[r_sel] + CW'(1);
                    r_rm_end     <= '0;
                end else if (r_idx != '0) begin
                    // full: drop oldest, place new at pos-1 via removal sweep
                    r_rm_end  <= r_idx;
                    r_rm_best <= 1'b0;
                    r_idx     <= '0;
                end else begin
                    // full and new entry is the oldest: drop it
                    r_full   <= 1'b0;
                    r_rm_end <= '0;
                end
            end
            if (i_cmd.scan_init) begin
                r_idx  <= CW'(1);
                r_best <= '0;
                r_bgap <= (r_pt[1][0] >= p0) ? r_pt[1][0] - p0 : p0 - r_pt[1][0];
            end
            if (i_cmd.scan_step) begin
                if (gap < r_bgap) begin
                    r_bgap <= gap;
                    r_best <= r_idx[IW-1:0];
                end
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.decide) begin
                r_idx <= '0;
                if (o_sts.hit) begin
                    o_res.matched       <= 1'b1;
                    o_res.frame_number  <= r_frame;
                    o_res.frame_time    <= p0;
                    o_res.primary_tag   <= r_pg[0][0];
                    o_res.secondary_tag <= r_pg[1][r_best];
                    r_frame   <= r_frame + FrameW'(1);
                    r_sel     <= 1'b0;
                    r_rm_best <= 1'b1;
                    r_rm_end  <= r_cnt[0];
                end else if (o_sts.p_stale) begin
                    r_sel     <= 1'b0;
                    r_rm_best <= 1'b0;
                    r_rm_end  <= r_cnt[0];
                    r_pd      <= r_pd + DropW'(1);
                end else begin
                    r_sel     <= 1'b1;
                    r_rm_best <= 1'b0;
                    r_rm_end  <= r_cnt[1];
                    r_sd      <= r_sd + DropW'(1);
                end
            end
            if (i_cmd.rm_step) begin
                if (o_sts.is_push) begin
                    if (r_full) begin
                        if (o_sts.rm_last) begin
                            r_pt[r_sel][r_idx[IW-1:0]] <= r_item.timestamp;
                            r_pg[r_sel][r_idx[IW-1:0]] <= r_item.tag;
                        end else begin
                            r_pt[r_sel][r_idx[IW-1:0]] <= r_pt[r_sel][r_idx[IW-1:0] + IW'(1)];
                            r_pg[r_sel][r_idx[IW-1:0]] <= r_pg[r_sel][r_idx[IW-1:0] + IW'(1)];
                        end
                    end
                end else begin
                    if (!o_sts.rm_last) begin
                        r_pt[r_sel][r_idx[IW-1:0]] <= r_pt[r_sel][r_idx[IW-1:0] + IW'(1)];
                        r_pg[r_sel][r_idx[IW-1:0]] <= r_pg[r_sel][r_idx[IW-1:0] + IW'(1)];
                    end
                    if (o_sts.rm_last) begin
                        r_cnt[r_sel] <= r_cnt[r_sel] - CW'(1);
                        if (r_rm_best) begin
                            // second removal: matched secondary entry
                            r_rm_best <= 1'b0;
                            r_sel     <= 1'b1;
                            r_rm_end  <= r_cnt[1];
                            r_idx     <= {{(CW-IW){1'b0}}, r_best};
                        end
                    end
                end
                if (!o_sts.rm_last) r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.emit) begin
                o_res.primary_dropped   <= r_pd;
                o_res.secondary_dropped <= r_sd;
            end
            if (i_cmd.load) o_res <= '0;
        end
    end

    `include "nearest_timestamp_pair_matcher_assert.svh"
    `NTPM_ASSERT_NOW(a_cnt_p, i_clk, i_rst_n, 1'b1, r_cnt[0] <= CW'(BUFFER_DEPTH), "primary count over depth")
    `NTPM_ASSERT_NOW(a_cnt_s, i_clk, i_rst_n, 1'b1, r_cnt[1] <= CW'(BUFFER_DEPTH), "secondary count over depth")
    `NTPM_ASSERT_NEXT(a_clr, i_clk, i_rst_n, i_cmd.clear, r_cnt[0] == '0 && r_frame == '0, "clear failed")
    `NTPM_ASSERT_NOW(a_one, i_clk, i_rst_n, 1'b1, $onehot0({i_cmd.ins_step, i_cmd.scan_step, i_cmd.rm_step}), "overlapping steps")
endmodule

[hw/rtl/ntpm_ctrl.sv]
// ----------------------------------------------------------------------------
// ntpm_ctrl
// Sequencer for push, match and clear operations.
// ----------------------------------------------------------------------------
module ntpm_ctrl import ntpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_RM   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_LOOP = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_hit, n_hit;
    logic       r_second, n_second;
    logic       r_done;

    always_comb begin
        n_state  = r_state;
        n_hit    = r_hit;
        n_second = r_second;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.is_match) begin
                    n_state = S_LOOP;
                end else if (i_sts.is_push) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INS: begin
                if (i_sts.ins_last) begin
                    o_cmd.ins_done = 1'b1;
                    n_state = S_RM;
                end else begin
                    o_cmd.ins_step = 1'b1;
                end
            end
            S_LOOP: begin
                if (i_sts.empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_DEC;
                else o_cmd.scan_step = 1'b1;
            end
            S_DEC: begin
                if (i_sts.hit || i_sts.p_stale || i_sts.s_stale) begin
                    o_cmd.decide = 1'b1;
                    n_hit   = i_sts.hit;
                    n_state = S_RM;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RM: begin
                if (i_sts.is_push) begin
                    // full-buffer sweep or nothing
                    o_cmd.rm_step = 1'b1;
                    if (i_sts.rm_last) n_state = S_IDLE;
                end else begin
                    o_cmd.rm_step = 1'b1;
                    if (i_sts.rm_last) begin
                        if (r_hit) begin
                            n_hit    = 1'b0;
                            n_second = 1'b1;
                            n_state  = S_RM;
                        end else if (r_second) begin
                            n_second = 1'b0;
                            n_state  = S_EMIT;
                        end else begin
                            n_state = S_LOOP;
                        end
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hit    <= 1'b0;
            r_second <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hit    <= n_hit;
            r_second <= n_second;
            r_done   <= o_cmd.emit;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    `include "nearest_timestamp_pair_matcher_assert.svh"
    `NTPM_ASSERT_NEXT(a_done, i_clk, i_rst_n, o_cmd.emit, o_done && !o_busy, "done not after emit")
    `NTPM_ASSERT_NOW(a_load, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE, "load outside idle")
    `NTPM_ASSERT_NOW(a_dec, i_clk, i_rst_n, o_cmd.decide, i_sts.is_match, "decide outside match")
endmodule

[hw/rtl/nearest_timestamp_pair_matcher.sv]
// Push: an insert walk, plus a shift sweep when the buffer is full. Match: per search, a scan
// of the secondary buffer, then on each removal a shift from the removed entry to the tail;
// o_done strobes in the same cycle that busy falls after a match. Clear and unusable push end
// at dispatch. Throughput: one operation at a time, start taken once busy is low; the
// receiver cannot stall. Reset (synchronous, active low) empties both buffers, zeroes the
// frame counter and loads the tolerance with 20000.
// ----------------------------------------------------------------------------
// nearest_timestamp_pair_matcher
// Pairs two timestamp-sorted sensor streams by nearest capture time.
// ----------------------------------------------------------------------------
module nearest_timestamp_pair_matcher import ntpm_pkg::*; #(
    parameter int BUFFER_DEPTH = DefDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    output logic        o_done,
    output t_out        o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd             cmd;
    t_sts             sts;
    logic [DiffW-1:0] r_max_diff;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, r_max_diff} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_diff <= DiffReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_max_diff <= pwdata[DiffW-1:0];
        end
    end

    ntpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ntpm_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_max_diff (r_max_diff),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_result)
    );
endmodule

[tb/tb_nearest_timestamp_pair_matcher.sv]
// ----------------------------------------------------------------------------
// Testbench for nearest_timestamp_pair_matcher
// Drives pushes, match requests and clears through the command port, keeps a
// predictor of both sorted buffers and the frame counter, and checks every
// match result field by field. Tolerance is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_nearest_timestamp_pair_matcher;
    import ntpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 16;
    localparam logic [1:0] AddrDiff = 2'd0;
    localparam longint CycleLimit = 10000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_done;
    t_out        o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_timestamp_pair_matcher #(.BUFFER_DEPTH(Depth)) dut (.*);

    always #5 i_clk = ~i_clk;

    logic [TimeW-1:0]  pri_time [Depth];
    logic [TagW-1:0]   pri_tag  [Depth];
    int                pri_cnt;
    logic [TimeW-1:0]  sec_time [Depth];
    logic [TagW-1:0]   sec_tag  [Depth];
    int                sec_cnt;
    logic [FrameW-1:0] frame_ctr;
    logic [DiffW-1:0]  tolerance;

    t_out   pending_results[$];
    int     errors = 0;
    longint cycles = 0;
    int     send_idle_pct = 0;
    logic [TimeW-1:0] clock_us = '0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_out w;
            if (pending_results.size() == 0) begin
                report("unexpected result", 64'(o_result.matched), 64'd0);
            end else begin
                w = pending_results[0];
                pending_results.delete(0);
                if (o_result.matched !== w.matched)
                    report("matched", 64'(o_result.matched), 64'(w.matched));
                if (o_result.frame_number !== w.frame_number)
                    report("frame_number", 64'(o_result.frame_number), 64'(w.frame_number));
                if (o_result.frame_time !== w.frame_time)
                    report("frame_time", 64'(o_result.frame_time), 64'(w.frame_time));
                if (o_result.primary_tag !== w.primary_tag)
                    report("primary_tag", 64'(o_result.primary_tag), 64'(w.primary_tag));
                if (o_result.secondary_tag !== w.secondary_tag)
                    report("secondary_tag", 64'(o_result.secondary_tag),
                           64'(w.secondary_tag));
                if (o_result.primary_dropped !== w.primary_dropped)
                    report("primary_dropped", 64'(o_result.primary_dropped),
                           64'(w.primary_dropped));
                if (o_result.secondary_dropped !== w.secondary_dropped)
                    report("secondary_dropped", 64'(o_result.secondary_dropped),
                           64'(w.secondary_dropped));
            end
        end
    end

    function automatic void insert_sorted(input bit to_sec, input logic [TimeW-1:0] t,
                                          input logic [TagW-1:0] g);
        logic [TimeW-1:0] tv [Depth+1];
        logic [TagW-1:0]  gv [Depth+1];
        int n, pos, k, first;
        n = to_sec ? sec_cnt : pri_cnt;
        for (k = 0; k < n; k++) begin
            tv[k] = to_sec ? sec_time[k] : pri_time[k];
            gv[k] = to_sec ? sec_tag[k] : pri_tag[k];
        end
        pos = 0;
        while (pos < n && tv[pos] <= t) pos++;
        for (k = n; k > pos; k--) begin
            tv[k] = tv[k-1];
            gv[k] = gv[k-1];
        end
        tv[pos] = t;
        gv[pos] = g;
        n++;
        first = (n > Depth) ? 1 : 0;
        n = n - first;
        for (k = 0; k < n; k++) begin
            if (to_sec) begin
                sec_time[k] = tv[k+first];
                sec_tag[k] = gv[k+first];
            end else begin
                pri_time[k] = tv[k+first];
                pri_tag[k] = gv[k+first];
            end
        end
        if (to_sec) sec_cnt = n;
        else pri_cnt = n;
    endfunction

    function automatic void drop_entry(input bit from_sec, input int idx);
        int k;
        if (from_sec) begin
            for (k = idx; k + 1 < sec_cnt; k++) begin
                sec_time[k] = sec_time[k+1];
                sec_tag[k] = sec_tag[k+1];
            end
            sec_cnt--;
        end else begin
            for (k = idx; k + 1 < pri_cnt; k++) begin
                pri_time[k] = pri_time[k+1];
                pri_tag[k] = pri_tag[k+1];
            end
            pri_cnt--;
        end
    endfunction

    function automatic t_out predict_match();
        t_out r;
        logic [TimeW-1:0] pt;
        logic [TimeW-1:0] gap, best_gap;
        int best, k;
        r = '0;
        while (pri_cnt > 0 && sec_cnt > 0) begin
            pt = pri_time[0];
            best = 0;
            best_gap = (sec_time[0] >= pt) ? sec_time[0] - pt : pt - sec_time[0];
            for (k = 1; k < sec_cnt; k++) begin
                gap = (sec_time[k] >= pt) ? sec_time[k] - pt : pt - sec_time[k];
                if (gap < best_gap) begin
                    best_gap = gap;
                    best = k;
                end
            end
            if (best_gap <= {24'd0, tolerance}) begin
                r.matched = 1'b1;
                r.frame_number = frame_ctr;
                r.frame_time = pt;
                r.primary_tag = pri_tag[0];
                r.secondary_tag = sec_tag[best];
                frame_ctr++;
                drop_entry(1'b0, 0);
                drop_entry(1'b1, best);
                break;
            end
            if ({1'b0, sec_time[0]} > {1'b0, pt} + tolerance) begin
                drop_entry(1'b0, 0);
                r.primary_dropped++;
                continue;
            end
            if ({1'b0, sec_time[sec_cnt-1]} + tolerance < {1'b0, pt}) begin
                drop_entry(1'b1, 0);
                r.secondary_dropped++;
                continue;
            end
            break;
        end
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [TimeW-1:0] ts,
                             input logic [TagW-1:0] tg, input logic use_it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_item <= '{operation: op, timestamp: ts, tag: tg, usable: use_it};
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (op)
            OpPushP: if (use_it) insert_sorted(1'b0, ts, tg);
            OpPushS: if (use_it) insert_sorted(1'b1, ts, tg);
            OpMatch: pending_results.push_back(predict_match());
            OpClear: begin
                pri_cnt = 0;
                sec_cnt = 0;
                frame_ctr = '0;
            end
        endcase
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_results.size() > 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (Depth * Depth + 50) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [DiffW-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= AddrDiff;
        pwdata <= {8'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tolerance = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1;
        paddr <= AddrDiff;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[DiffW-1:0] !== val)
            report("tolerance readback", 64'(prdata), 64'(val));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [TimeW-1:0] near_time(input int spread);
        return clock_us + $urandom_range(spread);
    endfunction

    task automatic test_directed();
        logic [TimeW-1:0] big;
        big = {TimeW{1'b1}};
        send_item(OpMatch, '0, '0, 1'b0);
        send_item(OpPushP, 48'd1000, 16'hFFFF, 1'b0);
        send_item(OpPushP, 48'd1000, 16'h0001, 1'b1);
        send_item(OpMatch, '0, '0, 1'b1);
        send_item(OpPushS, 48'd1500, 16'hAAAA, 1'b1);
        send_item(OpPushS, 48'd500, 16'h5555, 1'b1);
        send_item(OpMatch, big, 16'hFFFF, 1'b1);
        send_item(OpPushP, 48'd100, 16'h0002, 1'b1);
        send_item(OpPushP, 48'd900000, 16'h0003, 1'b1);
        send_item(OpMatch, '0, '0, 1'b0);
        send_item(OpPushP, big, 16'hFFFF, 1'b1);
        send_item(OpPushS, big, 16'h0000, 1'b1);
        send_item(OpPushS, big - 48'd5, 16'h1234, 1'b1);
        send_item(OpMatch, '0, '0, 1'b0);
        send_item(OpMatch, '0, '0, 1'b0);
        send_item(OpMatch, '0, '0, 1'b0);
        send_item(OpClear, big, 16'hFFFF, 1'b1);
        send_item(OpMatch, '0, '0, 1'b0);
        for (int k = 0; k < Depth + 3; k++)
            send_item(OpPushS, 48'd5000 + 48'(k % 4) * 48'd10, 16'(k), 1'b1);
        send_item(OpPushS, 48'd1, 16'hBEEF, 1'b1);
        send_item(OpPushP, 48'd5010, 16'hC0DE, 1'b1);
        send_item(OpMatch, '0, '0, 1'b0);
        drain();
    endtask

    task automatic test_random(input int n_items, input int spread);
        int sel;
        logic [TimeW-1:0] ts;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            if ($urandom_range(19) == 0) clock_us = TimeW'({$urandom, $urandom});
            clock_us = clock_us + $urandom_range(spread / 2);
            ts = near_time(spread);
            if ($urandom_range(49) == 0) ts = TimeW'({$urandom, $urandom});
            if (sel < 38)
                send_item(OpPushP, ts, 16'($urandom), $urandom_range(9) != 0);
            else if (sel < 76)
                send_item(OpPushS, ts, 16'($urandom), $urandom_range(9) != 0);
            else if (sel < 98)
                send_item(OpMatch, TimeW'({$urandom, $urandom}), 16'($urandom),
                          1'($urandom));
            else
                send_item(OpClear, TimeW'({$urandom, $urandom}), 16'($urandom),
                          1'($urandom));
        end
    endtask

    task automatic test_settings();
        send_idle_pct = 16;
        write_tolerance(24'd0);
        test_random(120, 8);
        drain();
        write_tolerance(24'hFFFFFF);
        test_random(120, 40000000);
        drain();
        send_idle_pct = 69;
        write_tolerance(24'd20000);
        test_random(250, 60000);
        drain();
        send_idle_pct = 0;
        write_tolerance(24'(1 + $urandom_range(3000)));
        test_random(250, 5000);
        drain();
        write_tolerance(24'd20000);
        test_random(190, 50000);
        drain();
    endtask

    initial begin
        pri_cnt = 0;
        sec_cnt = 0;
        frame_ctr = '0;
        tolerance = DiffReset;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_settings();
        if (pending_results.size() != 0)
            report("results missing", 64'(pending_results.size()), 64'd0);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
